/* rtl/core/mbe_pkg.sv */
// Package for the Mandelbrot escape-time block: fixed-point widths, constants,
// configuration register indexes, the multiplier request type and input saturation.
// No dependencies.
package mbe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int IN_W       = 31;
    localparam int Z_W        = 32;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W - FRAC_BITS;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ACC_W-1:0] ONE_A =
        {{(ACC_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] QUARTER_A   = ONE_A >>> 2;
    localparam logic signed [ACC_W-1:0] SIXTEENTH_A = ONE_A >>> 4;
    localparam logic signed [ACC_W-1:0] FOUR_A      = ONE_A <<< 2;
    localparam logic signed [IN_W-1:0]  TWO_IN      = IN_W'(ONE_A <<< 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CARDIOID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BULB     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd1024;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // Clamp an input coordinate to the range -2.0 .. +2.0.
    function automatic logic signed [Z_W-1:0] sat_in(input logic signed [IN_W-1:0] v);
        logic signed [IN_W-1:0] r;
        begin
            r = v;
            if (v > TWO_IN)
            begin
                r = TWO_IN;
            end
            else if (v < -TWO_IN)
            begin
                r = -TWO_IN;
            end
            return Z_W'(r);
        end
    endfunction

endpackage

/* rtl/core/mbe_mul.sv */
// Shared signed multiplier with a registered full-width product.
// Depends on mbe_pkg.
module mbe_mul
    import mbe_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;

    assign op_a = req.a;
    assign op_b = req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/mandelbrot_escape_time.sv */
// Mandelbrot escape-time block. S_IDLE takes the item, S_C1..S_C5 run the cardioid test,
// S_B1..S_B3 the bulb test, then each iteration steps through S_RR, S_II, S_RI and S_UPD;
// S_DONE loads the result once the output register is free. One item is in work at a time;
// every iteration makes three passes through the single shared multiplier.
// Reset (asynchronous, active low) sets cardioid_check=1, bulb_check=1, iteration_limit=1024
// and empties the result register.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [IN_W-1:0]       c_real,
    input  logic signed [IN_W-1:0]       c_imag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [CNT_W-1:0]             iter_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_C1, S_C2, S_C3, S_C4, S_C5, S_B1, S_B2, S_B3,
        S_RR, S_II, S_RI, S_UPD, S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic                     card_en_reg, card_en_next;
    logic                     bulb_en_reg, bulb_en_next;
    logic [CNT_W-1:0]         limit_reg, limit_next;
    logic signed [Z_W-1:0]    cr_reg, cr_next;
    logic signed [Z_W-1:0]    ci_reg, ci_next;
    logic signed [Z_W-1:0]    zr_reg, zr_next;
    logic signed [Z_W-1:0]    zi_reg, zi_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [ACC_W-1:0]  a_reg, a_next;
    logic signed [ACC_W-1:0]  b_reg, b_next;
    logic signed [ACC_W-1:0]  qt_reg, qt_next;
    logic signed [ACC_W-1:0]  rhs_reg, rhs_next;
    logic [CNT_W-1:0]         res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_q;
    logic signed [ACC_W-1:0]  prod_q2;
    logic signed [Z_W-1:0]    prod_ri;
    logic signed [ACC_W-1:0]  t_card;
    logic signed [ACC_W-1:0]  t_bulb;
    logic signed [ACC_W-1:0]  sum_q;

    mbe_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // Products truncated back to the fixed-point scale (floor, arithmetic shift).
    assign prod_q  = ACC_W'(prod >>> FRAC_BITS);
    assign prod_q2 = ACC_W'(prod >>> (FRAC_BITS + 2));
    assign prod_ri = Z_W'(prod >>> (FRAC_BITS - 1));

    assign t_card = ACC_W'(cr_reg) - QUARTER_A;
    assign t_bulb = ACC_W'(cr_reg) + ONE_A;
    assign sum_q  = a_reg + prod_q;

    always_comb
    begin
        mreq.a = MUL_W'(zr_reg);
        mreq.b = MUL_W'(zr_reg);
        case (state_reg)
            S_C1:
            begin
                mreq.a = MUL_W'(t_card);
                mreq.b = MUL_W'(t_card);
            end
            S_C2, S_B2:
            begin
                mreq.a = MUL_W'(ci_reg);
                mreq.b = MUL_W'(ci_reg);
            end
            S_C4:
            begin
                mreq.a = MUL_W'(b_reg);
                mreq.b = MUL_W'(qt_reg);
            end
            S_B1:
            begin
                mreq.a = MUL_W'(t_bulb);
                mreq.b = MUL_W'(t_bulb);
            end
            S_II:
            begin
                mreq.a = MUL_W'(zi_reg);
                mreq.b = MUL_W'(zi_reg);
            end
            S_RI:
            begin
                mreq.a = MUL_W'(zr_reg);
                mreq.b = MUL_W'(zi_reg);
            end
            default:
            begin
                mreq.a = MUL_W'(zr_reg);
                mreq.b = MUL_W'(zr_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        card_en_next   = card_en_reg;
        bulb_en_next   = bulb_en_reg;
        limit_next     = limit_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        n_next         = n_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        qt_next        = qt_reg;
        rhs_next       = rhs_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CARDIOID: card_en_next = cfg_data[0];
                CFG_BULB:     bulb_en_next = cfg_data[0];
                CFG_LIMIT:    limit_next   = cfg_data;
                default:      ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cr_next = sat_in(c_real);
                    ci_next = sat_in(c_imag);
                    zr_next = '0;
                    zi_next = '0;
                    n_next  = '0;
                    if (card_en_reg)
                    begin
                        state_next = S_C1;
                    end
                    else if (bulb_en_reg)
                    begin
                        state_next = S_B1;
                    end
                    else
                    begin
                        state_next = S_RR;
                    end
                end
            end
            S_C1: state_next = S_C2;
            S_C2:
            begin
                a_next     = prod_q;
                state_next = S_C3;
            end
            S_C3:
            begin
                // q and q + t, with the y^2/4 bound taken from the same product.
                b_next     = sum_q;
                qt_next    = sum_q + t_card;
                rhs_next   = prod_q2;
                state_next = S_C4;
            end
            S_C4: state_next = S_C5;
            S_C5:
            begin
                if (prod_q < rhs_reg)
                begin
                    res_next   = limit_reg;
                    state_next = S_DONE;
                end
                else if (bulb_en_reg)
                begin
                    state_next = S_B1;
                end
                else
                begin
                    state_next = S_RR;
                end
            end
            S_B1: state_next = S_B2;
            S_B2:
            begin
                a_next     = prod_q;
                state_next = S_B3;
            end
            S_B3:
            begin
                if (sum_q < SIXTEENTH_A)
                begin
                    res_next   = limit_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RR;
                end
            end
            S_RR:
            begin
                if (n_reg == limit_reg)
                begin
                    res_next   = n_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_II;
                end
            end
            S_II:
            begin
                a_next     = prod_q;
                state_next = S_RI;
            end
            S_RI:
            begin
                // The escape test sees zr^2 in a_reg and zi^2 straight off the multiplier.
                if (sum_q >= FOUR_A)
                begin
                    res_next   = n_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    b_next     = prod_q;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                zr_next    = Z_W'(a_reg - b_reg + ACC_W'(cr_reg));
                zi_next    = prod_ri + ci_reg;
                n_next     = n_reg + 1'b1;
                state_next = S_RR;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            card_en_reg   <= 1'b1;
            bulb_en_reg   <= 1'b1;
            limit_reg     <= LIMIT_RESET;
            cr_reg        <= '0;
            ci_reg        <= '0;
            zr_reg        <= '0;
            zi_reg        <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            qt_reg        <= '0;
            rhs_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            card_en_reg   <= card_en_next;
            bulb_en_reg   <= bulb_en_next;
            limit_reg     <= limit_next;
            cr_reg        <= cr_next;
            ci_reg        <= ci_next;
            zr_reg        <= zr_next;
            zi_reg        <= zi_next;
            n_reg         <= n_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            qt_reg        <= qt_next;
            rhs_reg       <= rhs_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign iter_count = out_count_reg;

endmodule

/* rtl/core/mbe_checker.sv */
// Port-level checks for the Mandelbrot escape-time block, bound to its top level.
// Depends on mbe_pkg and mandelbrot_escape_time.
module mbe_checker
    import mbe_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [CNT_W-1:0]       iter_count
);

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block took a second item right after the first");

    // A new result appears only as the block finishes an item and returns to idle.
    a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (in_ready && $past(!in_ready)))
        else $error("result appeared outside the end of an item");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(iter_count)))
        else $error("stalled result changed or dropped");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

/* verif/mandelbrot_escape_time_chk.sv */
// Checker for the Mandelbrot escape-time block: mirrors the configuration registers,
// predicts the iteration count of every accepted point and compares it with each result.
// Depends on mbe_pkg for the widths, the register indexes and the reset limit.
`timescale 1ns / 1ps

module mandelbrot_escape_time_chk
    import mbe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic signed [IN_W-1:0] c_real,
    input  logic signed [IN_W-1:0] c_imag,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [CNT_W-1:0]       iter_count,
    output int                     fail_count,
    output int                     pending
);

    localparam longint ONE_FX       = longint'(1) <<< FRAC_BITS;
    localparam longint TWO_FX       = ONE_FX * 2;
    localparam longint FOUR_FX      = ONE_FX * 4;
    localparam longint QUARTER_FX   = ONE_FX / 4;
    localparam longint SIXTEENTH_FX = ONE_FX / 16;

    typedef struct {
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        logic [CNT_W-1:0]       count;
    } escape_due_t;

    logic             cardioid_on;
    logic             bulb_on;
    logic [CNT_W-1:0] limit_q;
    escape_due_t      counts_due[$];
    escape_due_t      head;

    function automatic longint clamp_coord(input logic signed [IN_W-1:0] raw);
        longint v;
        begin
            v = raw;
            if (v > TWO_FX)
            begin
                v = TWO_FX;
            end
            else if (v < -TWO_FX)
            begin
                v = -TWO_FX;
            end
            return v;
        end
    endfunction

    // 64-bit product shifted back to the fixed-point scale, truncated toward minus infinity.
    function automatic longint fx_mul(input longint a, input longint b);
        begin
            return (a * b) >>> FRAC_BITS;
        end
    endfunction

    function automatic logic [CNT_W-1:0] escape_count(
        input logic signed [IN_W-1:0] re_raw,
        input logic signed [IN_W-1:0] im_raw,
        input logic                   card_en,
        input logic                   bulb_en,
        input logic [CNT_W-1:0]       limit
    );
        longint cr, ci, t, q, lhs, rhs, zr, zi, rr, ii, ri;
        int     n;
        begin
            cr = clamp_coord(re_raw);
            ci = clamp_coord(im_raw);
            if (card_en)
            begin
                t   = cr - QUARTER_FX;
                q   = fx_mul(t, t) + fx_mul(ci, ci);
                lhs = fx_mul(q, q + t);
                rhs = (ci * ci) >>> (FRAC_BITS + 2);
                if (lhs < rhs)
                begin
                    return limit;
                end
            end
            if (bulb_en)
            begin
                t = cr + ONE_FX;
                if (fx_mul(t, t) + fx_mul(ci, ci) < SIXTEENTH_FX)
                begin
                    return limit;
                end
            end
            zr = 0;
            zi = 0;
            n  = 0;
            while (n < limit)
            begin
                rr = fx_mul(zr, zr);
                ii = fx_mul(zi, zi);
                if (rr + ii >= FOUR_FX)
                begin
                    break;
                end
                // 2*zr*zi comes from one less shift.
                ri = (zr * zi) >>> (FRAC_BITS - 1);
                zr = rr - ii + cr;
                zi = ri + ci;
                n++;
            end
            return CNT_W'(n);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cardioid_on = 1'b1;
            bulb_on     = 1'b1;
            limit_q     = LIMIT_RESET;
            counts_due.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // Results are matched before a new item is queued in the same cycle.
            if (out_valid && out_ready)
            begin
                if (counts_due.size() == 0)
                begin
                    $error("iter_count %0d arrived with no item outstanding", iter_count);
                    fail_count++;
                end
                else
                begin
                    head = counts_due.pop_front();
                    if (iter_count !== head.count)
                    begin
                        $error("iter_count: expected %0d, actual %0d (c_real %0d, c_imag %0d)",
                               head.count, iter_count, head.re, head.im);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                head.re    = c_real;
                head.im    = c_imag;
                head.count = escape_count(c_real, c_imag, cardioid_on, bulb_on, limit_q);
                counts_due.push_back(head);
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_CARDIOID)
                begin
                    cardioid_on = cfg_data[0];
                end
                else if (cfg_index == CFG_BULB)
                begin
                    bulb_on = cfg_data[0];
                end
                else if (cfg_index == CFG_LIMIT)
                begin
                    limit_q = cfg_data[CNT_W-1:0];
                end
            end
            pending = counts_due.size();
        end
    end

endmodule

/* verif/mandelbrot_escape_time_tb.sv */
// Top of the testbench for the Mandelbrot escape-time block: clock, reset, points, register
// settings and the receiver's stalls; the checker beside the block does the comparing.
// Depends on mbe_pkg, mandelbrot_escape_time and mandelbrot_escape_time_chk.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
    import mbe_pkg::*;

    localparam int RUN_LIMIT = 4_000_000;
    localparam int ONE_C     = 1 << FRAC_BITS;
    localparam int TWO_C     = 2 * ONE_C;
    localparam int QTR_C     = ONE_C / 4;
    localparam int IN_MAX    = (1 << (IN_W - 1)) - 1;
    localparam int IN_MIN    = -(1 << (IN_W - 1));

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [IN_W-1:0] c_real;
    logic signed [IN_W-1:0] c_imag;
    logic                   out_valid;
    logic                   out_ready;
    logic [CNT_W-1:0]       iter_count;
    logic                   hold_req;
    int                     fail_count;
    int                     pending;
    int                     cycles = 0;

    always #2 clk = ~clk;

    mandelbrot_escape_time uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .c_real     (c_real),
        .c_imag     (c_imag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .iter_count (iter_count)
    );

    mandelbrot_escape_time_chk escape_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .c_real     (c_real),
        .c_imag     (c_imag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .iter_count (iter_count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_point(input int cr, input int ci);
        begin
            in_valid = 1'b1;
            c_real   = IN_W'(cr);
            c_imag   = IN_W'(ci);
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
        end
    endtask

    // Mostly points around the set, where the count varies; some are saturated or arbitrary.
    task automatic pick_point(output logic signed [IN_W-1:0] cr,
                              output logic signed [IN_W-1:0] ci);
        int kind;
        begin
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                cr = IN_W'($urandom());
                ci = IN_W'($urandom());
            end
            else if (kind < 6)
            begin
                cr = IN_W'(int'($urandom_range(0, 2 * TWO_C)) - TWO_C);
                ci = IN_W'(int'($urandom_range(0, 2 * TWO_C)) - TWO_C);
            end
            else
            begin
                cr = IN_W'(int'($urandom_range(0, 671088640)) - TWO_C);
                ci = IN_W'(int'($urandom_range(0, 644245094)) - 322122547);
            end
        end
    endtask

    task automatic run_points(input int count);
        int                     left;
        int                     burst;
        int                     gap;
        logic signed [IN_W-1:0] cr;
        logic signed [IN_W-1:0] ci;
        begin
            left = count;
            while (left > 0)
            begin
                burst = $urandom_range(1, 12);
                while (burst > 0 && left > 0)
                begin
                    pick_point(cr, ci);
                    send_point(int'(cr), int'(ci));
                    burst--;
                    left--;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            in_valid = 1'b0;
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid = 1'b0;
            while (pending != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_write = 1'b1;
            cfg_index = idx;
            cfg_data  = data;
            @(negedge clk);
            cfg_write = 1'b0;
        end
    endtask

    // The unused upper bits of the one-bit registers carry random data.
    task automatic set_config(input bit card, input bit bulb, input logic [CNT_W-1:0] limit);
        begin
            wait_idle();
            write_reg(CFG_CARDIOID, {(CFG_DATA_W-1)'($urandom()), card});
            write_reg(CFG_BULB, {(CFG_DATA_W-1)'($urandom()), bulb});
            write_reg(CFG_LIMIT, limit);
        end
    endtask

    initial
    begin : receiver
        int mode;
        int run;
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 40);
            repeat (run)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    // Long hold-off so that the block fills up and stalls its input.
                    out_ready = 1'b0;
                    repeat (300) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ~out_ready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int k;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        c_real    = '0;
        c_imag    = '0;
        hold_req  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed points at the reset settings: both early tests on, limit 1024.
        send_point(0, 0);
        send_point(-ONE_C, 0);
        send_point(TWO_C, 0);
        send_point(-TWO_C, 0);
        send_point(0, TWO_C);
        send_point(0, -TWO_C);
        send_point(IN_MAX, IN_MAX);
        send_point(IN_MIN, IN_MIN);
        send_point(IN_MAX, IN_MIN);
        // Cardioid cusp, the junction of cardioid and bulb, and the far edge of the bulb
        // sit on the test boundaries and never escape.
        send_point(QTR_C, 0);
        send_point(-3 * QTR_C, 0);
        send_point(-5 * QTR_C, 0);
        send_point(-ONE_C / 2, ONE_C / 2);
        send_point(-1, 0);
        send_point(0, -1);
        send_point(ONE_C / 2, 0);
        send_point(-ONE_C / 10, ONE_C / 20 * 13);
        send_point(ONE_C / 10 * 3, ONE_C / 2);
        send_point(-ONE_C / 10 * 17, 0);
        send_point(-ONE_C / 10, ONE_C);
        send_point(TWO_C, TWO_C);
        in_valid = 1'b0;

        set_config(1'b0, 1'b1, CNT_W'($urandom_range(16, 64)));
        run_points(40);
        set_config(1'b1, 1'b0, 16'd100);
        run_points(40);
        set_config(1'b0, 1'b0, 16'd1);
        run_points(30);
        set_config(1'b1, 1'b1, 16'd0);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        run_points(10);
        set_config(1'b1, 1'b1, 16'd255);
        hold_req = 1'b1;
        run_points(60);
        set_config(1'b1, 1'b1, LIMIT_RESET);
        run_points(20);

        // Largest limit: one full run to the cap, the rest escape after the first iteration.
        set_config(1'b0, 1'b0, 16'hFFFF);
        send_point(0, 0);
        send_point(TWO_C, TWO_C);
        send_point(IN_MIN, IN_MAX);
        in_valid = 1'b0;

        for (k = 0; k < 4; k++)
        begin
            set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       CNT_W'($urandom_range(2, 200)));
            run_points(20);
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mbe_pkg.sv
rtl/core/mbe_mul.sv
rtl/core/mandelbrot_escape_time.sv
rtl/core/mbe_checker.sv
verif/mandelbrot_escape_time_chk.sv
verif/mandelbrot_escape_time_tb.sv
